// ----- rtl/core/ppa_pkg.sv -----
// Shared types, constants and helper functions of the physical page allocator.
`default_nettype none

package ppa_pkg;

   localparam int PAGE_BITS   = 12;
   localparam int WORD_COUNT  = 64;
   localparam int WIDX_BITS   = 6;
   localparam int RANGE_COUNT = 5;
   localparam int RANGE_BITS  = 3;
   localparam int FREE_BITS   = 13;
   localparam int ADDR_BITS   = 24;

   localparam logic [PAGE_BITS-1:0] PAGE_MAX = '1;
   localparam logic [FREE_BITS-1:0] FREE_MAX = '1;

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_REF   = 2'd1;
   localparam logic [1:0] OP_DROP  = 2'd2;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_NOMEM = 2'd1;
   localparam logic [1:0] ST_BAD   = 2'd2;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_RANGE = 9'b000000010,
      S_SREAD = 9'b000000100,
      S_SBIT  = 9'b000001000,
      S_TREAD = 9'b000010000,
      S_TAKE  = 9'b000100000,
      S_RREAD = 9'b001000000,
      S_REF   = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   typedef struct packed {
      logic load;
      logic range_chk;
      logic rd_scan;
      logic scan_step;
      logic rd_take;
      logic take_step;
      logic rd_ref;
      logic ref_update;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic is_alloc;
      logic is_ref;
      logic range_ok;
      logic ref_bad;
      logic scan_end;
      logic scan_found;
      logic scan_wrap;
      logic take_end;
      logic take_wrap;
      logic rsp_free;
   } stat_type;

   function automatic logic [RANGE_BITS-1:0] range_of_page(input logic [PAGE_BITS-1:0] p);
      logic [31:0] pe;
      pe = {{(32-PAGE_BITS){1'b0}}, p};
      if ((pe >> (32 - PAGE_BITS)) != 32'd0) return 3'd4;
      else if ((pe >> (24 - PAGE_BITS)) != 32'd0) return 3'd3;
      else if ((pe >> (20 - PAGE_BITS)) != 32'd0) return 3'd2;
      else if ((pe >> (16 - PAGE_BITS)) != 32'd0) return 3'd1;
      else return 3'd0;
   endfunction

   function automatic logic [RANGE_BITS-1:0] range_of_bits(input logic [6:0] mb);
      if (mb == 7'd0 || mb >= 7'd64) return 3'd4;
      else if (mb > 7'd32) return 3'd4;
      else if (mb > 7'd24) return 3'd3;
      else if (mb > 7'd20) return 3'd2;
      else if (mb > 7'd16) return 3'd1;
      else return 3'd0;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ppa_ctrl.sv -----
// Controller state machine sequencing allocate, reference and drop requests.
`default_nettype none

module ppa_ctrl
   import ppa_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (stat.is_alloc) state_in = S_RANGE;
               else if (stat.is_ref) state_in = S_RREAD;
               else state_in = S_DONE;
            end
         end
         S_RANGE: begin
            cmd.range_chk = 1'b1;
            state_in = stat.range_ok ? S_SREAD : S_DONE;
         end
         S_SREAD: begin
            cmd.rd_scan = 1'b1;
            state_in = S_SBIT;
         end
         S_SBIT: begin
            cmd.scan_step = 1'b1;
            priority if (stat.scan_end) state_in = S_DONE;
            else if (stat.scan_found) state_in = S_TREAD;
            else if (stat.scan_wrap) state_in = S_SREAD;
            else state_in = S_SBIT;
         end
         S_TREAD: begin
            cmd.rd_take = 1'b1;
            state_in = S_TAKE;
         end
         S_TAKE: begin
            cmd.take_step = 1'b1;
            priority if (stat.take_end) state_in = S_DONE;
            else if (stat.take_wrap) state_in = S_TREAD;
            else state_in = S_TAKE;
         end
         S_RREAD: begin
            cmd.rd_ref = 1'b1;
            state_in = stat.ref_bad ? S_DONE : S_REF;
         end
         S_REF: begin
            cmd.ref_update = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/core/ppa_dp.sv -----
// Datapath: bitmaps, reference counts, range hints, scan and result registers.
`default_nettype none

module ppa_dp
   import ppa_pkg::*;
#(
   parameter int REF_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output stat_type                   stat,
   input  wire logic [1:0]            req_opcode,
   input  wire logic [PAGE_BITS-1:0]  req_page,
   input  wire logic [12:0]           req_run_length,
   input  wire logic [6:0]            req_max_bits,
   input  wire logic                  csr_write_enable,
   input  wire logic [PAGE_BITS-1:0]  csr_write_data,
   input  wire logic                  rsp_stall,
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_status,
   output logic [ADDR_BITS-1:0]       rsp_phys_addr
);

   localparam logic [REF_BITS-1:0] REF_MAX = '1;

   logic [1:0]             op_ff;
   logic [PAGE_BITS-1:0]   page_ff;
   logic [12:0]            n_ff;
   logic [6:0]             mb_ff;
   logic [PAGE_BITS-1:0]   max_page_ff;
   logic [1:0]             res_status_ff;
   logic [ADDR_BITS-1:0]   res_addr_ff;
   logic [12:0]            a_ff;
   logic [PAGE_BITS-1:0]   last_ff;
   logic [12:0]            cnt_ff;
   logic [PAGE_BITS-1:0]   p_ff;
   logic [12:0]            i_ff;
   logic [63:0]            word_ff;
   logic                   fresh_ff;
   logic [63:0]            summary_ff;
   logic                   rsp_valid_ff;
   logic [1:0]             rsp_status_ff;
   logic [ADDR_BITS-1:0]   rsp_addr_ff;

   logic [FREE_BITS-1:0]   free_ff  [RANGE_COUNT];
   logic [PAGE_BITS-1:0]   first_ff [RANGE_COUNT];
   logic [PAGE_BITS-1:0]   lastr_ff [RANGE_COUNT];

   logic [63:0]            used_mem  [WORD_COUNT];
   logic [63:0]            multi_mem [WORD_COUNT];
   logic [REF_BITS-1:0]    cnt_mem   [1 << PAGE_BITS];
   logic [WORD_COUNT-1:0]  used_vld_ff, multi_vld_ff;
   logic [63:0]            used_rd_ff, multi_rd_ff;
   logic                   used_rv_ff, multi_rv_ff;
   logic [REF_BITS-1:0]    cnt_rd_ff;

   logic [63:0]            used_q, multi_q, cur_word;
   logic [WIDX_BITS-1:0]   rd_addr;
   logic                   rd_en;

   logic [RANGE_BITS-1:0]  r0, sel;
   logic                   range_ok;

   logic                   scan_end, full_word, abit, found, wrap;
   logic [12:0]            cnt_inc, a_next;
   logic [PAGE_BITS-1:0]   start;

   logic                   upd_take, upd_free;
   logic [PAGE_BITS-1:0]   upd_page;
   logic [63:0]            upd_word;
   logic [RANGE_BITS-1:0]  ur;

   logic                   multi_we, cnt_we;
   logic [63:0]            multi_wd;
   logic [REF_BITS-1:0]    cnt_wd, cnt_dec;
   logic [63:0]            pbit, tbit;
   logic                   pused, pmulti, ref_bad;

   assign used_q   = used_rv_ff ? used_rd_ff : '1;
   assign multi_q  = multi_rv_ff ? multi_rd_ff : '0;
   assign cur_word = fresh_ff ? used_q : word_ff;
   assign ref_bad  = (page_ff > max_page_ff);

   always_comb begin
      r0  = range_of_bits(mb_ff);
      sel = '0;
      for (int k = 0; k < RANGE_COUNT; k++) begin
         if (RANGE_BITS'(k) <= r0 && free_ff[k] != '0) sel = RANGE_BITS'(k);
      end
      range_ok = (free_ff[sel] != '0) && (n_ff != 13'd0) && (free_ff[sel] >= n_ff);
   end

   always_comb begin
      scan_end  = (a_ff > {1'b0, last_ff}) || (&summary_ff);
      full_word = &cur_word;
      abit      = cur_word[a_ff[WIDX_BITS-1:0]];
      cnt_inc   = cnt_ff + 13'd1;
      found     = !scan_end && !full_word && !abit && (cnt_inc == n_ff);
      wrap      = !scan_end && !found && (full_word || (&a_ff[WIDX_BITS-1:0]));
      a_next    = full_word ? {a_ff[12:WIDX_BITS] + 7'd1, {WIDX_BITS{1'b0}}} : a_ff + 13'd1;
      start     = PAGE_BITS'(a_ff + 13'd1 - n_ff);
   end

   always_comb begin
      rd_en   = cmd.rd_scan | cmd.rd_take | cmd.rd_ref;
      rd_addr = page_ff[PAGE_BITS-1:WIDX_BITS];
      if (cmd.rd_scan) rd_addr = a_ff[PAGE_BITS-1:WIDX_BITS];
      else if (cmd.rd_take) rd_addr = p_ff[PAGE_BITS-1:WIDX_BITS];
   end

   always_comb begin
      pbit     = 64'd1 << page_ff[WIDX_BITS-1:0];
      tbit     = 64'd1 << p_ff[WIDX_BITS-1:0];
      pused    = used_q[page_ff[WIDX_BITS-1:0]];
      pmulti   = multi_q[page_ff[WIDX_BITS-1:0]];
      cnt_dec  = (cnt_rd_ff == '0) ? '0 : cnt_rd_ff - REF_BITS'(1);
      upd_take = 1'b0;
      upd_free = 1'b0;
      upd_page = page_ff;
      upd_word = used_q;
      multi_we = 1'b0;
      multi_wd = multi_q;
      cnt_we   = 1'b0;
      cnt_wd   = cnt_rd_ff;
      if (cmd.take_step) begin
         upd_take = 1'b1;
         upd_page = p_ff;
         upd_word = cur_word | tbit;
      end else if (cmd.ref_update) begin
         if (op_ff == OP_REF) begin
            if (pused) begin
               if (!pmulti) begin
                  multi_we = 1'b1;
                  multi_wd = multi_q | pbit;
                  cnt_we   = 1'b1;
                  cnt_wd   = REF_BITS'(2);
               end else if (cnt_rd_ff != REF_MAX) begin
                  cnt_we = 1'b1;
                  cnt_wd = cnt_rd_ff + REF_BITS'(1);
               end
            end else begin
               upd_take = 1'b1;
               upd_word = used_q | pbit;
            end
         end else if (pused) begin
            if (pmulti) begin
               cnt_we = 1'b1;
               cnt_wd = cnt_dec;
               if (cnt_dec <= REF_BITS'(1)) begin
                  multi_we = 1'b1;
                  multi_wd = multi_q & ~pbit;
               end
               if (cnt_dec == '0) begin
                  upd_free = 1'b1;
                  upd_word = used_q & ~pbit;
               end
            end else begin
               upd_free = 1'b1;
               upd_word = used_q & ~pbit;
            end
         end
      end
      ur = range_of_page(upd_page);
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         used_rd_ff  <= used_mem[rd_addr];
         multi_rd_ff <= multi_mem[rd_addr];
         cnt_rd_ff   <= cnt_mem[page_ff];
      end
      if (upd_take | upd_free) used_mem[upd_page[PAGE_BITS-1:WIDX_BITS]] <= upd_word;
      if (multi_we) multi_mem[page_ff[PAGE_BITS-1:WIDX_BITS]] <= multi_wd;
      if (cnt_we) cnt_mem[page_ff] <= cnt_wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_vld_ff  <= '0;
         multi_vld_ff <= '0;
         used_rv_ff   <= 1'b0;
         multi_rv_ff  <= 1'b0;
         summary_ff   <= '1;
         max_page_ff  <= PAGE_MAX;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < RANGE_COUNT; k++) begin
            free_ff[k]  <= '0;
            first_ff[k] <= PAGE_MAX;
            lastr_ff[k] <= '0;
         end
      end else begin
         if (rd_en) begin
            used_rv_ff  <= used_vld_ff[rd_addr];
            multi_rv_ff <= multi_vld_ff[rd_addr];
         end
         if (upd_take | upd_free) begin
            used_vld_ff[upd_page[PAGE_BITS-1:WIDX_BITS]] <= 1'b1;
            summary_ff[upd_page[PAGE_BITS-1:WIDX_BITS]]  <= &upd_word;
         end
         if (multi_we) multi_vld_ff[page_ff[PAGE_BITS-1:WIDX_BITS]] <= 1'b1;
         if (upd_take) begin
            if (free_ff[ur] != '0) free_ff[ur] <= free_ff[ur] - FREE_BITS'(1);
            if (upd_page == first_ff[ur] && first_ff[ur] != PAGE_MAX) begin
               first_ff[ur] <= first_ff[ur] + PAGE_BITS'(1);
            end
         end
         if (upd_free) begin
            if (free_ff[ur] != FREE_MAX) free_ff[ur] <= free_ff[ur] + FREE_BITS'(1);
            if (first_ff[ur] > upd_page) first_ff[ur] <= upd_page;
            if (lastr_ff[ur] < upd_page) lastr_ff[ur] <= upd_page;
         end
         if (csr_write_enable) max_page_ff <= csr_write_data;
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff         <= req_opcode;
         page_ff       <= req_page;
         n_ff          <= req_run_length;
         mb_ff         <= req_max_bits;
         res_status_ff <= ST_DONE;
         res_addr_ff   <= '0;
      end
      if (cmd.range_chk) begin
         a_ff    <= {1'b0, first_ff[sel]};
         last_ff <= lastr_ff[sel];
         cnt_ff  <= '0;
         if (!range_ok) res_status_ff <= ST_NOMEM;
      end
      if (rd_en) fresh_ff <= 1'b1;
      if (cmd.scan_step) begin
         fresh_ff <= 1'b0;
         word_ff  <= cur_word;
         a_ff     <= a_next;
         cnt_ff   <= (full_word || abit) ? 13'd0 : cnt_inc;
         if (scan_end) res_status_ff <= ST_NOMEM;
         if (found) begin
            p_ff        <= start;
            i_ff        <= '0;
            res_addr_ff <= {start, {(ADDR_BITS-PAGE_BITS){1'b0}}};
         end
      end
      if (cmd.take_step) begin
         fresh_ff <= 1'b0;
         word_ff  <= upd_word;
         p_ff     <= p_ff + PAGE_BITS'(1);
         i_ff     <= i_ff + 13'd1;
      end
      if (cmd.rd_ref && ref_bad) res_status_ff <= ST_BAD;
      if (cmd.emit) begin
         rsp_status_ff <= res_status_ff;
         rsp_addr_ff   <= res_addr_ff;
      end
   end

   always_comb begin
      stat            = '0;
      stat.is_alloc   = (req_opcode == OP_ALLOC);
      stat.is_ref     = (req_opcode == OP_REF) || (req_opcode == OP_DROP);
      stat.range_ok   = range_ok;
      stat.ref_bad    = ref_bad;
      stat.scan_end   = scan_end;
      stat.scan_found = found;
      stat.scan_wrap  = wrap;
      stat.take_end   = (i_ff + 13'd1 == n_ff);
      stat.take_wrap  = &p_ff[WIDX_BITS-1:0];
      stat.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_phys_addr = rsp_addr_ff;

endmodule

`default_nettype wire

// ----- rtl/core/physical_page_allocator.sv -----
// Top level of the physical page allocator: controller, datapath and checks.
`default_nettype none

// One request at a time; req_stall stays high from acceptance until the response is
// loaded into the output register. Reference and drop requests read the page's bitmap
// word and count, update them and then hand over the response; a page out of range
// skips the update, and an unknown opcode goes straight to the response. An allocation
// checks the range, then scans the pages between the range's first and last free hint,
// reading each bitmap word and passing over a fully used word at once, and then marks
// the run page by page, reading each word that it marks; the bitmap is one word memory
// read once per word and tested one page per cycle. No clearing pass is needed after
// reset.
module physical_page_allocator
   import ppa_pkg::*;
#(
   parameter int REF_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_opcode,
   input  wire logic [PAGE_BITS-1:0]  req_page,
   input  wire logic [12:0]           req_run_length,
   input  wire logic [6:0]            req_max_bits,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic [ADDR_BITS-1:0]       rsp_phys_addr,
   input  wire logic                  csr_write_enable,
   input  wire logic [PAGE_BITS-1:0]  csr_write_data
);

   cmd_type  cmd;
   stat_type stat;

   ppa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ppa_dp #(
      .REF_BITS (REF_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_opcode       (req_opcode),
      .req_page         (req_page),
      .req_run_length   (req_run_length),
      .req_max_bits     (req_max_bits),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_phys_addr    (rsp_phys_addr)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("accepted request did not raise stall");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != 2'd3))
      else $error("illegal response status");

   a_addr_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_NOMEM || rsp_status == ST_BAD)) |->
      (rsp_phys_addr == '0))
      else $error("nonzero address on failed request");

   a_emit_when_busy: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid)) |-> $past(req_stall))
      else $error("response produced while idle");

endmodule

`default_nettype wire
